// ===== rtl/nhth_pkg.sv =====
// ----------------------------------------------------------------------------
// NH Toeplitz hash package
// Shared constants, opcodes and datapath types of the NH Toeplitz hash unit.
// ----------------------------------------------------------------------------
package nhth_pkg;

    localparam int ROWS   = 4;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int WORDS  = 4;
    localparam int WORD_W = 32;
    localparam int LANE_W = 64;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_ABSORB = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;

    typedef logic [WORDS-1:0][WORD_W-1:0] block_t;
    typedef block_t [ROWS-1:0]            row_block_t;
    typedef logic [WORDS-1:0][LANE_W-1:0] prod_t;
    typedef prod_t [ROWS-1:0]             row_prod_t;
    typedef logic [1:0][LANE_W-1:0]       acc_t;
    typedef acc_t [ROWS-1:0]              row_acc_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] opcode;
    } in_ctl_t;

    typedef struct packed {
        logic valid;
        logic fin;
    } stage_ctl_t;

endpackage

// ===== rtl/nhth_key_sched.sv =====
// ----------------------------------------------------------------------------
// NH Toeplitz key schedule
// Key window, lane sums against every row and even-block hold; issues
// multiply operand pairs and finish markers.
// ----------------------------------------------------------------------------
module nhth_key_sched (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  nhth_pkg::in_ctl_t   in_ctl,
    input  nhth_pkg::block_t    data,
    input  nhth_pkg::block_t    key,
    output nhth_pkg::stage_ctl_t out_ctl,
    output nhth_pkg::row_block_t x_op,
    output nhth_pkg::row_block_t y_op
);
    import nhth_pkg::*;

    row_block_t kw_reg, kw_next;
    row_block_t held_reg, held_next;
    row_block_t sums;
    row_block_t x_reg, y_reg;
    logic       pair_reg, pair_next;
    stage_ctl_t ctl_reg, ctl_next;
    logic       issue_mul;

    always_comb begin
        for (int r = 0; r < ROWS; r++) begin
            for (int w = 0; w < WORDS; w++) begin
                sums[r][w] = data[w] + kw_reg[r][w];
            end
        end
    end

    always_comb begin
        kw_next   = kw_reg;
        held_next = held_reg;
        pair_next = pair_reg;
        ctl_next  = ctl_reg;
        issue_mul = 1'b0;
        if (advance) begin
            ctl_next = '0;
            if (in_ctl.valid) begin
                case (in_ctl.opcode)
                    OP_LOAD: begin
                        for (int r = 0; r < ROWS - 1; r++) begin
                            kw_next[r] = kw_reg[r+1];
                        end
                        kw_next[ROWS-1] = key;
                    end
                    OP_ABSORB: begin
                        if (!pair_reg) begin
                            held_next = sums;
                            pair_next = 1'b1;
                        end else begin
                            issue_mul      = 1'b1;
                            ctl_next.valid = 1'b1;
                            pair_next      = 1'b0;
                        end
                        for (int r = 0; r < ROWS - 1; r++) begin
                            kw_next[r] = kw_reg[r+1];
                        end
                        kw_next[ROWS-1] = key;
                    end
                    OP_FINISH: begin
                        pair_next      = 1'b0;
                        ctl_next.valid = 1'b1;
                        ctl_next.fin   = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kw_reg   <= '0;
            held_reg <= '0;
            pair_reg <= 1'b0;
            ctl_reg  <= '0;
        end else begin
            kw_reg   <= kw_next;
            held_reg <= held_next;
            pair_reg <= pair_next;
            ctl_reg  <= ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue_mul) begin
            x_reg <= held_reg;
            y_reg <= sums;
        end
    end

    assign out_ctl = ctl_reg;
    assign x_op    = x_reg;
    assign y_op    = y_reg;

endmodule

// ===== rtl/nhth_mac.sv =====
// ----------------------------------------------------------------------------
// NH Toeplitz multiply-accumulate
// Registered 32x32 lane products, then per-row 64-bit accumulation; a finish
// marker hands the accumulators to the tag stage and clears them.
// ----------------------------------------------------------------------------
module nhth_mac (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 advance,
    input  nhth_pkg::stage_ctl_t in_ctl,
    input  nhth_pkg::row_block_t x_op,
    input  nhth_pkg::row_block_t y_op,
    output nhth_pkg::stage_ctl_t prod_ctl,
    output logic                 tag_load,
    output nhth_pkg::row_acc_t   acc
);
    import nhth_pkg::*;

    row_prod_t  prod_reg;
    stage_ctl_t ctl_reg;
    row_acc_t   acc_reg, acc_next;

    always_comb begin
        acc_next = acc_reg;
        tag_load = 1'b0;
        if (advance && ctl_reg.valid) begin
            if (ctl_reg.fin) begin
                tag_load = 1'b1;
                acc_next = '0;
            end else begin
                for (int r = 0; r < ROWS; r++) begin
                    acc_next[r][0] = acc_reg[r][0] + prod_reg[r][0] + prod_reg[r][1];
                    acc_next[r][1] = acc_reg[r][1] + prod_reg[r][2] + prod_reg[r][3];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
            acc_reg <= '0;
        end else begin
            acc_reg <= acc_next;
            if (advance) begin
                ctl_reg <= in_ctl;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_ctl.valid && !in_ctl.fin) begin
            for (int r = 0; r < ROWS; r++) begin
                for (int w = 0; w < WORDS; w++) begin
                    prod_reg[r][w] <= LANE_W'(x_op[r][w]) * LANE_W'(y_op[r][w]);
                end
            end
        end
    end

    assign prod_ctl = ctl_reg;
    assign acc      = acc_reg;

endmodule

// ===== rtl/nhth_tag_out.sv =====
// ----------------------------------------------------------------------------
// NH Toeplitz tag output
// Holds a snapshot of the row accumulators and sends one row per output handshake.
// ----------------------------------------------------------------------------
module nhth_tag_out (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               tag_load,
    input  nhth_pkg::row_acc_t acc,
    output logic               busy,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [63:0]        m_tag_low,
    output logic [63:0]        m_tag_high,
    output logic [1:0]         m_row_index,
    output logic               m_last_part
);
    import nhth_pkg::*;

    row_acc_t         snap_reg;
    logic             busy_reg;
    logic [ROW_W-1:0] part_reg;
    logic [1:0]       row_reg;
    logic             last;

    assign last = (part_reg == ROW_W'(ROWS - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            part_reg <= '0;
            row_reg  <= '0;
        end else if (tag_load) begin
            busy_reg <= 1'b1;
            part_reg <= '0;
            row_reg  <= '0;
        end else if (busy_reg && m_ready) begin
            if (last) begin
                busy_reg <= 1'b0;
            end else begin
                part_reg <= part_reg + ROW_W'(1);
                row_reg  <= row_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (tag_load) begin
            snap_reg <= acc;
        end
    end

    assign busy        = busy_reg;
    assign m_valid     = busy_reg;
    assign m_tag_low   = snap_reg[part_reg][0];
    assign m_tag_high  = snap_reg[part_reg][1];
    assign m_row_index = row_reg;
    assign m_last_part = last;

endmodule

// ===== rtl/nh_toeplitz_hash_unit.sv =====
// ----------------------------------------------------------------------------
// NH Toeplitz hash unit
// NH universal hash over 128-bit blocks with a four-row Toeplitz key window.
// ----------------------------------------------------------------------------
// Input channel (s_*): one request per block. Load-key requests prime the key
// window; absorb requests carry a data block and the key four blocks ahead;
// a finish request closes the run and returns the tag.
// Output channel (m_*): a finish returns one part per row, row 0 first, with
// m_last_part on the final row.
// Throughput: one request per cycle while s_ready is high, through the input register,
// the lane-add stage, the registered 32x32 multipliers and the accumulators.
// Tag path: a finish passes the input register, the key-schedule and multiply-stage
// control registers before the tag snapshot; parts follow one per cycle while m_ready is high.
// A stalled receiver holds the tag; requests keep flowing until a second
// finish reaches the accumulators, which then holds s_ready low until the
// previous tag has been fully taken.
// Reset clears the key window, held sums, pair flag and accumulators, and
// drops any pending tag.
// ----------------------------------------------------------------------------
module nh_toeplitz_hash_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [63:0] s_data_low,
    input  logic [63:0] s_data_high,
    input  logic [63:0] s_key_low,
    input  logic [63:0] s_key_high,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_tag_low,
    output logic [63:0] m_tag_high,
    output logic [1:0]  m_row_index,
    output logic        m_last_part
);
    import nhth_pkg::*;

    in_ctl_t    in_ctl_reg;
    block_t     data_reg;
    block_t     key_reg;
    stage_ctl_t mul_ctl;
    stage_ctl_t prod_ctl;
    row_block_t x_op, y_op;
    row_acc_t   acc;
    logic       tag_load;
    logic       tag_busy;
    logic       advance;

    assign advance = !(prod_ctl.valid && prod_ctl.fin && tag_busy);
    assign s_ready = advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_ctl_reg.valid <= 1'b0;
        end else if (advance) begin
            in_ctl_reg.valid <= s_valid;
        end
        if (advance && s_valid) begin
            in_ctl_reg.opcode <= s_opcode;
            data_reg          <= {s_data_high, s_data_low};
            key_reg           <= {s_key_high, s_key_low};
        end
    end

    nhth_key_sched u_key_sched (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .in_ctl  (in_ctl_reg),
        .data    (data_reg),
        .key     (key_reg),
        .out_ctl (mul_ctl),
        .x_op    (x_op),
        .y_op    (y_op)
    );

    nhth_mac u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .in_ctl   (mul_ctl),
        .x_op     (x_op),
        .y_op     (y_op),
        .prod_ctl (prod_ctl),
        .tag_load (tag_load),
        .acc      (acc)
    );

    nhth_tag_out u_tag_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .tag_load    (tag_load),
        .acc         (acc),
        .busy        (tag_busy),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_tag_low   (m_tag_low),
        .m_tag_high  (m_tag_high),
        .m_row_index (m_row_index),
        .m_last_part (m_last_part)
    );

endmodule

// ===== rtl/nhth_checker.sv =====
// ----------------------------------------------------------------------------
// NH Toeplitz hash port checker
// Port-level checks on the tag output of the hash unit.
// ----------------------------------------------------------------------------
module nhth_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [63:0] m_tag_low,
    input logic [63:0] m_tag_high,
    input logic [1:0]  m_row_index,
    input logic        m_last_part
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_tag_low) && $stable(m_tag_high)
            && $stable(m_row_index) && $stable(m_last_part))
        else $error("tag part changed while stalled");

    a_parts_contiguous: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_part |=> m_valid
            && (m_row_index == $past(m_row_index) + 2'd1))
        else $error("tag parts not in row order");

    a_first_row: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> m_row_index == 2'd0)
        else $error("tag does not start at row zero");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

bind nh_toeplitz_hash_unit nhth_checker u_nhth_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_tag_low   (m_tag_low),
    .m_tag_high  (m_tag_high),
    .m_row_index (m_row_index),
    .m_last_part (m_last_part)
);
